// ----- src/pts_pkg.sv -----
package pts_pkg;

    // Defaults for the top-level parameters
    localparam int KEYWORD_MAX_LEN = 9;
    localparam int POSITION_BITS   = 32;

    // Token kinds
    localparam logic [5:0] KIND_EOF      = 6'd0;
    localparam logic [5:0] KIND_IDENT    = 6'd1;
    localparam logic [5:0] KIND_KW_FIRST = 6'd2;
    localparam logic [5:0] KIND_LITERAL  = 6'd37;
    localparam logic [5:0] KIND_INTEGER  = 6'd38;
    localparam logic [5:0] KIND_REAL     = 6'd39;
    localparam logic [5:0] KIND_PLUS     = 6'd40;
    localparam logic [5:0] KIND_MINUS    = 6'd41;
    localparam logic [5:0] KIND_STAR     = 6'd42;
    localparam logic [5:0] KIND_SLASH    = 6'd43;
    localparam logic [5:0] KIND_SEMI     = 6'd44;
    localparam logic [5:0] KIND_CARET    = 6'd45;
    localparam logic [5:0] KIND_LSQUARE  = 6'd46;
    localparam logic [5:0] KIND_RSQUARE  = 6'd47;
    localparam logic [5:0] KIND_RPAREN   = 6'd48;
    localparam logic [5:0] KIND_LPAREN   = 6'd49;
    localparam logic [5:0] KIND_COMMA    = 6'd50;
    localparam logic [5:0] KIND_EQUAL    = 6'd51;
    localparam logic [5:0] KIND_NE       = 6'd52;
    localparam logic [5:0] KIND_LE       = 6'd53;
    localparam logic [5:0] KIND_LT       = 6'd54;
    localparam logic [5:0] KIND_GE       = 6'd55;
    localparam logic [5:0] KIND_GT       = 6'd56;
    localparam logic [5:0] KIND_DOTDOT   = 6'd57;
    localparam logic [5:0] KIND_DOT      = 6'd58;
    localparam logic [5:0] KIND_DEFINE   = 6'd59;
    localparam logic [5:0] KIND_COLON    = 6'd60;
    localparam logic [5:0] KIND_BAD      = 6'd61;

    // Characters
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = " ";
    localparam logic [7:0] CH_QUOTE   = "'";
    localparam logic [7:0] CH_LT      = "<";
    localparam logic [7:0] CH_GT      = ">";
    localparam logic [7:0] CH_DOT     = ".";
    localparam logic [7:0] CH_COLON   = ":";
    localparam logic [7:0] CH_EQUAL   = "=";
    localparam logic [7:0] CH_PLUS    = "+";
    localparam logic [7:0] CH_MINUS   = "-";
    localparam logic [7:0] CH_STAR    = "*";
    localparam logic [7:0] CH_SLASH   = "/";
    localparam logic [7:0] CH_SEMI    = ";";
    localparam logic [7:0] CH_CARET   = "^";
    localparam logic [7:0] CH_LSQUARE = "[";
    localparam logic [7:0] CH_RSQUARE = "]";
    localparam logic [7:0] CH_RPAREN  = ")";
    localparam logic [7:0] CH_LPAREN  = "(";
    localparam logic [7:0] CH_COMMA   = ",";
    localparam logic [7:0] CH_EXP     = "e";

    // Keyword table: text padded to nine characters, first character in the top byte
    localparam int KW_COUNT    = 35;
    localparam int KW_TEXT_LEN = 9;
    localparam int KW_LEN_BITS = 5;

    localparam logic [KW_TEXT_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
        "and      ", "array    ", "begin    ", "case     ", "const    ",
        "div      ", "do       ", "downto   ", "else     ", "end      ",
        "file     ", "for      ", "function ", "goto     ", "if       ",
        "in       ", "label    ", "mod      ", "nil      ", "not      ",
        "of       ", "or       ", "packed   ", "procedure", "program  ",
        "record   ", "repeat   ", "set      ", "then     ", "to       ",
        "type     ", "until    ", "var      ", "while    ", "with     "
    };

    localparam logic [KW_LEN_BITS-1:0] KW_LEN [KW_COUNT] = '{
        5'd3, 5'd5, 5'd5, 5'd4, 5'd5,
        5'd3, 5'd2, 5'd6, 5'd4, 5'd3,
        5'd4, 5'd3, 5'd8, 5'd4, 5'd2,
        5'd2, 5'd5, 5'd3, 5'd3, 5'd3,
        5'd2, 5'd2, 5'd6, 5'd9, 5'd7,
        5'd6, 5'd6, 5'd3, 5'd4, 5'd2,
        5'd4, 5'd5, 5'd3, 5'd5, 5'd4
    };

    // Output queue and stream packing
    localparam int OUT_DEPTH     = 4;
    localparam int OUT_PTR_BITS  = 2;
    localparam int OUT_CNT_BITS  = 3;
    localparam int OUT_TDATA_W   = 72;
    localparam int OUT_PAD       = 2;

    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] start;
        logic [31:0] length;
        logic        last;
    } result_t;

    // Up to two results written per input transfer, in order
    typedef struct packed {
        logic [1:0] cnt;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic logic is_numeral(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_TAB) || (c == CH_SPACE) || (c == CH_NEWLINE);
    endfunction

    // Word text: byte i of the word at [i*8 +: 8]
    function automatic logic [5:0] kw_kind(input logic [KW_TEXT_LEN*8-1:0] text,
                                           input logic [KW_LEN_BITS-1:0]   len);
        logic [5:0] kind;
        logic       hit;
        kind = KIND_IDENT;
        for (int k = 0; k < KW_COUNT; k++) begin
            hit = (len == KW_LEN[k]);
            for (int i = 0; i < KW_TEXT_LEN; i++) begin
                if (i < int'(KW_LEN[k])) begin
                    hit = hit &&
                          (text[i*8 +: 8] == KW_TEXT[k][(KW_TEXT_LEN-1-i)*8 +: 8]);
                end
            end
            if (hit) begin
                kind = KIND_KW_FIRST + 6'(k);
            end
        end
        return kind;
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] kind;
        case (c)
            CH_PLUS:    kind = KIND_PLUS;
            CH_MINUS:   kind = KIND_MINUS;
            CH_STAR:    kind = KIND_STAR;
            CH_SLASH:   kind = KIND_SLASH;
            CH_SEMI:    kind = KIND_SEMI;
            CH_CARET:   kind = KIND_CARET;
            CH_LSQUARE: kind = KIND_LSQUARE;
            CH_RSQUARE: kind = KIND_RSQUARE;
            CH_RPAREN:  kind = KIND_RPAREN;
            CH_LPAREN:  kind = KIND_LPAREN;
            CH_COMMA:   kind = KIND_COMMA;
            CH_EQUAL:   kind = KIND_EQUAL;
            default:    kind = KIND_BAD;
        endcase
        return kind;
    endfunction

endpackage

// ----- src/pts_out_fifo.sv -----
module pts_out_fifo (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  pts_pkg::push_t                    push,
    output logic                              room,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [pts_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // kind, start, length, pad
    output logic                              m_axis_tlast
);

    pts_pkg::result_t                          entry_reg [pts_pkg::OUT_DEPTH];
    logic [pts_pkg::OUT_PTR_BITS-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [pts_pkg::OUT_PTR_BITS-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [pts_pkg::OUT_CNT_BITS-1:0]          count_reg, count_next;
    logic                                      pop;
    pts_pkg::result_t                          head;

    assign head          = entry_reg[rd_ptr_reg];
    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tdata  = {{pts_pkg::OUT_PAD{1'b0}}, head.length, head.start, head.kind};
    assign m_axis_tlast  = head.last;
    assign pop           = m_axis_tvalid && m_axis_tready;
    // room for the worst case of two results from one transfer
    assign room          = (count_reg <= pts_pkg::OUT_CNT_BITS'(pts_pkg::OUT_DEPTH - 2));

    always_comb begin
        rd_ptr_next = rd_ptr_reg + pts_pkg::OUT_PTR_BITS'(pop);
        wr_ptr_next = wr_ptr_reg + pts_pkg::OUT_PTR_BITS'(push.cnt);
        count_next  = count_reg + pts_pkg::OUT_CNT_BITS'(push.cnt)
                      - pts_pkg::OUT_CNT_BITS'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.cnt == 2'd2) begin
            entry_reg[wr_ptr_reg + pts_pkg::OUT_PTR_BITS'(1)] <= push.second;
        end
    end

endmodule

// ----- src/pascal_token_scanner_top.sv -----
// Pascal token scanner.
// Input stream: one source byte per transfer in s_axis_tdata; s_axis_tuser marks
// end of input, which flushes any pending token, reports eof and restarts the
// offsets from zero. Blanks (tab, space, newline) are skipped silently.
// Output stream: one token per transfer, kind, start offset and length packed in
// m_axis_tdata; m_axis_tlast flags the last token caused by one input transfer.
// A byte causes zero, one or two tokens (the token it terminates, then its own
// one-byte token or eof).
// Throughput: one input byte per clock while the queue has room. Each byte is
// decoded combinationally against the registered scanner state; its tokens land
// in a four-entry output queue, whose registered head drives m_axis.
// s_axis_tready is high while the queue has two free entries, so a stalled
// receiver holds back the input once three tokens are waiting; bytes that cause
// no token still pass until then. Nothing is dropped.
// Reset (aresetn low, synchronous) empties the queue and returns the scanner to
// offset zero with no pending token.
module pascal_token_scanner_top #(
    parameter int KeywordMaxLen = pts_pkg::KEYWORD_MAX_LEN,
    parameter int PositionBits  = pts_pkg::POSITION_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // source_byte
    input  logic [0:0]                      s_axis_tuser,   // end_of_input
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [5:0] token_kind, [37:6] token_start, [69:38] token_length, [71:70] zero
    output logic [pts_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast
);

    localparam int WordIdxBits = $clog2(KeywordMaxLen);

    // scanner modes
    localparam logic [3:0] M_IDLE      = 4'd0;
    localparam logic [3:0] M_WORD      = 4'd1;
    localparam logic [3:0] M_INT       = 4'd2;
    localparam logic [3:0] M_FRAC      = 4'd3;
    localparam logic [3:0] M_EXP_START = 4'd4;
    localparam logic [3:0] M_EXP_DIG   = 4'd5;
    localparam logic [3:0] M_LIT       = 4'd6;
    localparam logic [3:0] M_LT        = 4'd7;
    localparam logic [3:0] M_GT        = 4'd8;
    localparam logic [3:0] M_DOT       = 4'd9;
    localparam logic [3:0] M_COLON     = 4'd10;

    logic [3:0]              mode_reg, mode_next;
    logic                    too_long_reg, too_long_next;
    logic [PositionBits-1:0] pos_reg, pos_next;
    logic [PositionBits-1:0] begin_reg, begin_next;
    logic [7:0]              word_buf_reg [KeywordMaxLen];   // no reset: written before read

    logic                    accept;
    logic [7:0]              c;
    logic                    eoi;
    logic [PositionBits-1:0] run_len;
    logic [PositionBits-1:0] close_len;
    logic [pts_pkg::KW_TEXT_LEN*8-1:0] word_text;
    logic [5:0]              word_kind;
    logic                    flush_valid;
    logic [5:0]              flush_kind;

    // extension of the pending token by the current byte
    logic                    ext;
    logic                    ext_emit;
    logic                    ext_store;
    logic [5:0]              ext_kind;
    logic [3:0]              ext_mode;

    logic                    buf_we;
    logic [WordIdxBits-1:0]  buf_widx;

    logic                    r0_v, r1_v;
    logic [5:0]              r0_kind, r1_kind;
    logic [PositionBits-1:0] r0_start, r0_len, r1_start, r1_len;

    pts_pkg::push_t          push;
    logic                    room;

    function automatic logic [31:0] to_out(input logic [PositionBits-1:0] v);
        logic [63:0] wide;
        wide = 64'(v);
        return wide[31:0];
    endfunction

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = room;
    assign c             = s_axis_tdata;
    assign eoi           = s_axis_tuser[0];
    assign run_len       = pos_reg - begin_reg;
    assign close_len     = pos_reg + PositionBits'(1) - begin_reg;

    always_comb begin
        for (int i = 0; i < pts_pkg::KW_TEXT_LEN; i++) begin
            word_text[i*8 +: 8] = word_buf_reg[i];
        end
    end

    // keyword lookup only when the word fits the buffer
    always_comb begin
        if (too_long_reg || (run_len > PositionBits'(KeywordMaxLen))) begin
            word_kind = pts_pkg::KIND_IDENT;
        end else begin
            word_kind = pts_pkg::kw_kind(word_text, run_len[pts_pkg::KW_LEN_BITS-1:0]);
        end
    end

    always_comb begin
        flush_valid = 1'b1;
        case (mode_reg)
            M_WORD:      flush_kind = word_kind;
            M_INT:       flush_kind = pts_pkg::KIND_INTEGER;
            M_FRAC:      flush_kind = pts_pkg::KIND_REAL;
            M_EXP_START: flush_kind = pts_pkg::KIND_REAL;
            M_EXP_DIG:   flush_kind = pts_pkg::KIND_REAL;
            M_LIT:       flush_kind = pts_pkg::KIND_LITERAL;
            M_LT:        flush_kind = pts_pkg::KIND_LT;
            M_GT:        flush_kind = pts_pkg::KIND_GT;
            M_DOT:       flush_kind = pts_pkg::KIND_DOT;
            M_COLON:     flush_kind = pts_pkg::KIND_COLON;
            default: begin
                flush_valid = 1'b0;
                flush_kind  = pts_pkg::KIND_EOF;
            end
        endcase
    end

    always_comb begin
        ext       = 1'b0;
        ext_emit  = 1'b0;
        ext_store = 1'b0;
        ext_kind  = pts_pkg::KIND_LITERAL;
        ext_mode  = mode_reg;
        case (mode_reg)
            M_WORD: begin
                ext       = pts_pkg::is_letter(c) || pts_pkg::is_numeral(c);
                ext_store = ext;
            end
            M_INT: begin
                if (pts_pkg::is_numeral(c)) begin
                    ext = 1'b1;
                end else if (c == pts_pkg::CH_DOT) begin
                    ext      = 1'b1;
                    ext_mode = M_FRAC;
                end else if (c == pts_pkg::CH_EXP) begin
                    ext      = 1'b1;
                    ext_mode = M_EXP_START;
                end
            end
            M_FRAC: begin
                if (pts_pkg::is_numeral(c)) begin
                    ext = 1'b1;
                end else if (c == pts_pkg::CH_EXP) begin
                    ext      = 1'b1;
                    ext_mode = M_EXP_START;
                end
            end
            M_EXP_START: begin
                if ((c == pts_pkg::CH_PLUS) || (c == pts_pkg::CH_MINUS) ||
                    pts_pkg::is_numeral(c)) begin
                    ext      = 1'b1;
                    ext_mode = M_EXP_DIG;
                end
            end
            M_EXP_DIG: begin
                ext = pts_pkg::is_numeral(c);
            end
            M_LIT: begin
                // everything up to the closing quote belongs to the literal
                ext = 1'b1;
                if (c == pts_pkg::CH_QUOTE) begin
                    ext_emit = 1'b1;
                    ext_mode = M_IDLE;
                end
            end
            M_LT: begin
                if (c == pts_pkg::CH_GT) begin
                    ext      = 1'b1;
                    ext_emit = 1'b1;
                    ext_kind = pts_pkg::KIND_NE;
                    ext_mode = M_IDLE;
                end else if (c == pts_pkg::CH_EQUAL) begin
                    ext      = 1'b1;
                    ext_emit = 1'b1;
                    ext_kind = pts_pkg::KIND_LE;
                    ext_mode = M_IDLE;
                end
            end
            M_GT: begin
                if (c == pts_pkg::CH_EQUAL) begin
                    ext      = 1'b1;
                    ext_emit = 1'b1;
                    ext_kind = pts_pkg::KIND_GE;
                    ext_mode = M_IDLE;
                end
            end
            M_DOT: begin
                if (c == pts_pkg::CH_DOT) begin
                    ext      = 1'b1;
                    ext_emit = 1'b1;
                    ext_kind = pts_pkg::KIND_DOTDOT;
                    ext_mode = M_IDLE;
                end
            end
            M_COLON: begin
                if (c == pts_pkg::CH_EQUAL) begin
                    ext      = 1'b1;
                    ext_emit = 1'b1;
                    ext_kind = pts_pkg::KIND_DEFINE;
                    ext_mode = M_IDLE;
                end
            end
            default: begin
                ext = 1'b0;
            end
        endcase
    end

    // next state and the (up to two) results of the current transfer
    always_comb begin
        mode_next     = mode_reg;
        too_long_next = too_long_reg;
        pos_next      = pos_reg;
        begin_next    = begin_reg;
        buf_we        = 1'b0;
        buf_widx      = '0;
        r0_v          = 1'b0;
        r0_kind       = flush_kind;
        r0_start      = begin_reg;
        r0_len        = run_len;
        r1_v          = 1'b0;
        r1_kind       = pts_pkg::KIND_EOF;
        r1_start      = pos_reg;
        r1_len        = '0;
        if (accept) begin
            if (eoi) begin
                r0_v          = flush_valid;
                r1_v          = 1'b1;
                mode_next     = M_IDLE;
                too_long_next = 1'b0;
                pos_next      = '0;
                begin_next    = '0;
            end else begin
                pos_next = pos_reg + PositionBits'(1);
                if (ext) begin
                    mode_next = ext_mode;
                    r0_v      = ext_emit;
                    r0_kind   = ext_kind;
                    r0_len    = close_len;
                    if (ext_store) begin
                        if (!too_long_reg && (run_len < PositionBits'(KeywordMaxLen))) begin
                            buf_we   = 1'b1;
                            buf_widx = run_len[WordIdxBits-1:0];
                        end else begin
                            too_long_next = 1'b1;
                        end
                    end
                end else begin
                    // byte ends the pending token and starts its own
                    r0_v      = flush_valid;
                    mode_next = M_IDLE;
                    if (!pts_pkg::is_blank(c)) begin
                        begin_next = pos_reg;
                        if (pts_pkg::is_letter(c)) begin
                            mode_next     = M_WORD;
                            too_long_next = 1'b0;
                            buf_we        = 1'b1;
                        end else if (pts_pkg::is_numeral(c)) begin
                            mode_next = M_INT;
                        end else begin
                            case (c)
                                pts_pkg::CH_QUOTE: mode_next = M_LIT;
                                pts_pkg::CH_LT:    mode_next = M_LT;
                                pts_pkg::CH_GT:    mode_next = M_GT;
                                pts_pkg::CH_DOT:   mode_next = M_DOT;
                                pts_pkg::CH_COLON: mode_next = M_COLON;
                                default: begin
                                    r1_v    = 1'b1;
                                    r1_kind = pts_pkg::single_kind(c);
                                    r1_len  = PositionBits'(1);
                                end
                            endcase
                        end
                    end
                end
            end
        end
    end

    // pack results in order; the later one carries tlast
    always_comb begin
        push.cnt           = 2'(r0_v) + 2'(r1_v);
        push.second.kind   = r1_kind;
        push.second.start  = to_out(r1_start);
        push.second.length = to_out(r1_len);
        push.second.last   = 1'b1;
        if (r0_v) begin
            push.first.kind   = r0_kind;
            push.first.start  = to_out(r0_start);
            push.first.length = to_out(r0_len);
            push.first.last   = !r1_v;
        end else begin
            push.first = push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= M_IDLE;
            too_long_reg <= 1'b0;
            pos_reg      <= '0;
            begin_reg    <= '0;
        end else begin
            mode_reg     <= mode_next;
            too_long_reg <= too_long_next;
            pos_reg      <= pos_next;
            begin_reg    <= begin_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (buf_we) begin
            word_buf_reg[buf_widx] <= c;
        end
    end

    pts_out_fifo u_out_fifo (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .push          (push),
        .room          (room),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ----- src/pts_checker.sv -----
module pts_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [0:0]                      s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [pts_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tlast
);

    logic [5:0]  kind;
    logic [31:0] length;

    assign kind   = m_axis_tdata[5:0];
    assign length = m_axis_tdata[69:38];

    // queue is empty straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output transfer changed");

    // end of input always yields at least the eof token
    a_eof_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && s_axis_tuser[0] |=> m_axis_tvalid)
        else $error("no token after end of input");

    a_eof_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (kind == pts_pkg::KIND_EOF) |-> (length == 32'd0) && m_axis_tlast)
        else $error("malformed eof token");

    a_bad_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (kind == pts_pkg::KIND_BAD) |-> (length == 32'd1) && m_axis_tlast)
        else $error("malformed stray-byte token");

endmodule

bind pascal_token_scanner_top pts_checker u_pts_checker (.*);

// ----- test/tb_pascal_token_scanner_top.sv -----
module tb_pascal_token_scanner_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pts_pkg::*;

    // ------------------------------------------------------------------
    // Clock, reset and the ports of the block
    // ------------------------------------------------------------------
    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata  = 8'h00;  // source_byte
    logic [0:0]             s_axis_tuser  = 1'b0;   // end_of_input
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [5:0] token_kind, [37:6] token_start, [69:38] token_length, [71:70] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    always #5 aclk = ~aclk;

    pascal_token_scanner_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // ------------------------------------------------------------------
    // Types and tables
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] start;
        logic [31:0] length;
        logic        last;
    } token_t;

    // One source transfer; hold_off makes the sender wait until every
    // token already due has come out before offering it
    typedef struct {
        logic [7:0] ch;
        logic       eoi;
        bit         hold_off;
    } src_item_t;

    // What the scanner is in the middle of between two bytes
    typedef enum logic [3:0] {
        SCAN_IDLE,
        SCAN_WORD,
        SCAN_INT,
        SCAN_FRAC,
        SCAN_EXP_START,
        SCAN_EXP_DIGITS,
        SCAN_LITERAL,
        SCAN_LESS,
        SCAN_GREATER,
        SCAN_DOT,
        SCAN_COLON
    } scan_mode_e;

    // Keywords in kind order: kind = KIND_KW_FIRST + index
    string kw_words [35] = '{
        "and", "array", "begin", "case", "const", "div", "do", "downto", "else",
        "end", "file", "for", "function", "goto", "if", "in", "label", "mod",
        "nil", "not", "of", "or", "packed", "procedure", "program", "record",
        "repeat", "set", "then", "to", "type", "until", "var", "while", "with"
    };

    // Punctuation spellings used by the stimulus, lookahead pairs included
    string punct_words [21] = '{
        "+", "-", "*", "/", ";", "^", "[", "]", ")", "(", ",", "=",
        "<>", "<=", "<", ">=", ">", "..", ".", ":=", ":"
    };

    // ------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------
    src_item_t   src_items [$];     // bytes still to be offered to the block
    token_t      tokens_due [$];    // tokens predicted but not yet seen
    int unsigned mismatch_count = 0;
    bit          mid_hold_done  = 1'b0;
    bit          hold_next      = 1'b0;

    // Scanner copy kept by the testbench
    scan_mode_e  scan_mode  = SCAN_IDLE;
    logic [7:0]  word_text [KEYWORD_MAX_LEN];
    logic        word_long  = 1'b0;
    logic [31:0] src_pos    = '0;
    logic [31:0] tok_begin  = '0;

    // Tokens caused by the transfer being predicted (at most two)
    token_t      step_out [2];
    int          step_n;

    // ------------------------------------------------------------------
    // Token prediction
    // ------------------------------------------------------------------
    function automatic bit is_num_char(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic bit is_gap_char(logic [7:0] c);
        return c == CH_TAB || c == CH_SPACE || c == CH_NEWLINE;
    endfunction

    function automatic void emit_token(logic [5:0] k, logic [31:0] st, logic [31:0] ln);
        step_out[step_n] = '{kind: k, start: st, length: ln, last: 1'b0};
        step_n++;
    endfunction

    // Case-sensitive keyword lookup; only the bytes of the current word are read
    function automatic logic [5:0] word_token_kind(logic [31:0] n);
        bit hit;
        if (word_long || n > KEYWORD_MAX_LEN) return KIND_IDENT;
        for (int k = 0; k < 35; k++) begin
            if (kw_words[k].len() == int'(n)) begin
                hit = 1'b1;
                for (int i = 0; i < kw_words[k].len(); i++) begin
                    if (word_text[i] != 8'(kw_words[k][i])) hit = 1'b0;
                end
                if (hit) return KIND_KW_FIRST + 6'(k);
            end
        end
        return KIND_IDENT;
    endfunction

    function automatic void keep_word_char(logic [7:0] c);
        logic [31:0] wl;
        wl = src_pos - tok_begin;
        if (!word_long && wl < KEYWORD_MAX_LEN) word_text[wl] = c;
        else word_long = 1'b1;
    endfunction

    // Emit whatever token is open, then go idle
    function automatic void flush_open_token();
        logic [31:0] n;
        n = src_pos - tok_begin;
        case (scan_mode)
            SCAN_WORD:       emit_token(word_token_kind(n), tok_begin, n);
            SCAN_INT:        emit_token(KIND_INTEGER, tok_begin, n);
            SCAN_FRAC,
            SCAN_EXP_START,
            SCAN_EXP_DIGITS: emit_token(KIND_REAL, tok_begin, n);
            SCAN_LITERAL:    emit_token(KIND_LITERAL, tok_begin, n);
            SCAN_LESS:       emit_token(KIND_LT, tok_begin, n);
            SCAN_GREATER:    emit_token(KIND_GT, tok_begin, n);
            SCAN_DOT:        emit_token(KIND_DOT, tok_begin, n);
            SCAN_COLON:      emit_token(KIND_COLON, tok_begin, n);
            default: ;
        endcase
        scan_mode = SCAN_IDLE;
    endfunction

    // 1 when the byte belongs to the open token (possibly closing it)
    function automatic bit grow_open_token(logic [7:0] c);
        logic [5:0] pair;
        pair = KIND_EOF;    // no pair found
        case (scan_mode)
            SCAN_WORD: begin
                if (is_alpha(c) || is_num_char(c)) begin
                    keep_word_char(c);
                    return 1'b1;
                end
                return 1'b0;
            end
            SCAN_INT: begin
                if (is_num_char(c)) return 1'b1;
                if (c == CH_DOT) begin
                    scan_mode = SCAN_FRAC;
                    return 1'b1;
                end
                if (c == CH_EXP) begin
                    scan_mode = SCAN_EXP_START;
                    return 1'b1;
                end
                return 1'b0;
            end
            SCAN_FRAC: begin
                if (is_num_char(c)) return 1'b1;
                if (c == CH_EXP) begin
                    scan_mode = SCAN_EXP_START;
                    return 1'b1;
                end
                return 1'b0;
            end
            SCAN_EXP_START: begin
                if (c == CH_PLUS || c == CH_MINUS || is_num_char(c)) begin
                    scan_mode = SCAN_EXP_DIGITS;
                    return 1'b1;
                end
                return 1'b0;
            end
            SCAN_EXP_DIGITS: return is_num_char(c);
            SCAN_LITERAL: begin
                if (c == CH_QUOTE) begin
                    emit_token(KIND_LITERAL, tok_begin, src_pos + 1 - tok_begin);
                    scan_mode = SCAN_IDLE;
                end
                return 1'b1;
            end
            SCAN_LESS: begin
                if (c == CH_GT) pair = KIND_NE;
                else if (c == CH_EQUAL) pair = KIND_LE;
            end
            SCAN_GREATER: if (c == CH_EQUAL) pair = KIND_GE;
            SCAN_DOT:     if (c == CH_DOT) pair = KIND_DOTDOT;
            SCAN_COLON:   if (c == CH_EQUAL) pair = KIND_DEFINE;
            default: return 1'b0;
        endcase
        if (pair == KIND_EOF) return 1'b0;
        emit_token(pair, tok_begin, src_pos + 1 - tok_begin);
        scan_mode = SCAN_IDLE;
        return 1'b1;
    endfunction

    function automatic void open_token(logic [7:0] c);
        logic [5:0] k;
        if (is_gap_char(c)) return;
        tok_begin = src_pos;
        if (is_alpha(c)) begin
            scan_mode = SCAN_WORD;
            word_long = 1'b0;
            keep_word_char(c);
            return;
        end
        if (is_num_char(c)) begin
            scan_mode = SCAN_INT;
            return;
        end
        case (c)
            CH_QUOTE: begin scan_mode = SCAN_LITERAL; return; end
            CH_LT:    begin scan_mode = SCAN_LESS;    return; end
            CH_GT:    begin scan_mode = SCAN_GREATER; return; end
            CH_DOT:   begin scan_mode = SCAN_DOT;     return; end
            CH_COLON: begin scan_mode = SCAN_COLON;   return; end
            CH_PLUS:    k = KIND_PLUS;
            CH_MINUS:   k = KIND_MINUS;
            CH_STAR:    k = KIND_STAR;
            CH_SLASH:   k = KIND_SLASH;
            CH_SEMI:    k = KIND_SEMI;
            CH_CARET:   k = KIND_CARET;
            CH_LSQUARE: k = KIND_LSQUARE;
            CH_RSQUARE: k = KIND_RSQUARE;
            CH_RPAREN:  k = KIND_RPAREN;
            CH_LPAREN:  k = KIND_LPAREN;
            CH_COMMA:   k = KIND_COMMA;
            CH_EQUAL:   k = KIND_EQUAL;
            default:    k = KIND_BAD;
        endcase
        emit_token(k, src_pos, 32'd1);
    endfunction

    // Work out the tokens of one accepted input transfer and queue them
    function automatic void scan_transfer(logic [7:0] c, logic eoi);
        step_n = 0;
        if (eoi) begin
            flush_open_token();
            emit_token(KIND_EOF, src_pos, 32'd0);
            src_pos   = '0;
            tok_begin = '0;
            word_long = 1'b0;
        end else begin
            if (!grow_open_token(c)) begin
                flush_open_token();
                open_token(c);
            end
            src_pos = src_pos + 1;
        end
        for (int i = 0; i < step_n; i++) begin
            if (i == step_n - 1) step_out[i].last = 1'b1;
            tokens_due.push_back(step_out[i]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    function automatic void report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%s", what);
    endfunction

    function automatic void check_token(logic [5:0] k, logic [31:0] st, logic [31:0] ln,
                                        logic lst);
        token_t want;
        if (tokens_due.size() == 0) begin
            report_mismatch($sformatf("unexpected token: kind %0d start %0d len %0d last %0b",
                                      k, st, ln, lst));
            return;
        end
        want = tokens_due.pop_front();
        if (k !== want.kind)
            report_mismatch($sformatf("token kind: expected %0d, got %0d", want.kind, k));
        if (st !== want.start)
            report_mismatch($sformatf("token start: expected %0d, got %0d", want.start, st));
        if (ln !== want.length)
            report_mismatch($sformatf("token length: expected %0d, got %0d", want.length, ln));
        if (lst !== want.last)
            report_mismatch($sformatf("tlast: expected %0b, got %0b", want.last, lst));
    endfunction

    // Idling is off in the final stretch and in every fourth block of 100
    // bytes, so that there are long runs at full rate as well
    function automatic bit calm_phase();
        return src_items.size() < 150 || (src_items.size() / 100) % 4 == 1;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers queued bytes on s_axis and predicts each transfer
    // ------------------------------------------------------------------
    int unsigned src_gap = 0;
    src_item_t   src_next;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            // A transfer at this edge: predict from the values it carried
            if (s_axis_tvalid && s_axis_tready) scan_transfer(s_axis_tdata, s_axis_tuser[0]);

            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (src_items.size() > 0 &&
                             !(src_items[0].hold_off && tokens_due.size() > 0)) begin
                    src_next = src_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= src_next.ch;
                    s_axis_tuser  <= src_next.eoi;
                    if (!calm_phase() && $urandom_range(0, 4) == 0)
                        src_gap = $urandom_range(1, 11);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure on m_axis, every transfer checked
    // ------------------------------------------------------------------
    int unsigned sink_gap = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                check_token(m_axis_tdata[5:0], m_axis_tdata[37:6], m_axis_tdata[69:38],
                            m_axis_tlast);

            if (sink_gap > 0) begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (!calm_phase() && $urandom_range(0, 7) == 0)
                    sink_gap = $urandom_range(1, 11);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    function automatic void queue_byte(logic [7:0] c);
        src_items.push_back('{ch: c, eoi: 1'b0, hold_off: hold_next});
        hold_next = 1'b0;
    endfunction

    function automatic void queue_text(string s);
        for (int i = 0; i < s.len(); i++) queue_byte(8'(s[i]));
    endfunction

    // The data byte is ignored with end of input, so it is random
    function automatic void queue_eoi();
        src_items.push_back('{ch: 8'($urandom_range(0, 255)), eoi: 1'b1, hold_off: hold_next});
        hold_next = 1'b0;
    endfunction

    function automatic logic [7:0] random_letter();
        if ($urandom_range(0, 5) == 0) return 8'h41 + 8'($urandom_range(0, 25));
        return 8'h61 + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] random_digit();
        return 8'h30 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] random_blank();
        case ($urandom_range(0, 2))
            0:       return CH_TAB;
            1:       return CH_NEWLINE;
            default: return CH_SPACE;
        endcase
    endfunction

    // Mostly well-formed Pascal tokens, with some noise bytes among them
    function automatic void queue_random_token();
        int         pick;
        int         n;
        logic [7:0] c;
        string      w;
        pick = $urandom_range(0, 99);
        if (pick < 18) begin
            queue_text(kw_words[$urandom_range(0, 34)]);
        end else if (pick < 30) begin
            // identifier, now and then longer than any keyword
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 16) : $urandom_range(1, 8);
            queue_byte(random_letter());
            repeat (n - 1)
                queue_byte(($urandom_range(0, 3) == 0) ? random_digit() : random_letter());
        end else if (pick < 35) begin
            // near miss: keyword with a capital, a trailing char or cut short
            w = kw_words[$urandom_range(0, 34)];
            case ($urandom_range(0, 2))
                0: begin
                    n = $urandom_range(0, w.len() - 1);
                    w[n] = byte'(w[n] - 8'h20);
                    queue_text(w);
                end
                1: begin
                    queue_text(w);
                    queue_byte(($urandom_range(0, 1) == 1) ? random_digit() : random_letter());
                end
                default: queue_text(w.substr(0, w.len() - 2));
            endcase
        end else if (pick < 50) begin
            // number: digits, optional fraction, optional exponent
            repeat ($urandom_range(1, 4)) queue_byte(random_digit());
            if ($urandom_range(0, 1) == 1) begin
                queue_byte(CH_DOT);
                repeat ($urandom_range(0, 3)) queue_byte(random_digit());
            end
            if ($urandom_range(0, 2) == 0) begin
                queue_byte(CH_EXP);
                case ($urandom_range(0, 3))
                    0: queue_byte(CH_PLUS);
                    1: queue_byte(CH_MINUS);
                    default: ;
                endcase
                repeat ($urandom_range(0, 2)) queue_byte(random_digit());
            end
        end else if (pick < 57) begin
            // quoted literal with any content; some are left open
            queue_byte(CH_QUOTE);
            repeat ($urandom_range(0, 6)) begin
                do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
                queue_byte(c);
            end
            if ($urandom_range(0, 9) != 0) queue_byte(CH_QUOTE);
        end else if (pick < 82) begin
            queue_text(punct_words[$urandom_range(0, 20)]);
        end else if (pick < 92) begin
            repeat ($urandom_range(1, 3)) queue_byte(random_blank());
        end else begin
            queue_byte(8'($urandom_range(0, 255)));
        end
    endfunction

    // ------------------------------------------------------------------
    // Sequence: stimulus, reset, wait for the last token, verdict
    // ------------------------------------------------------------------
    initial begin
        // Directed: longest keyword, := and 1e (real of length 2), eof
        queue_text("procedure:=1e");
        queue_eoi();
        // top byte, carriage return, zero byte, then a lone < flushed by eof
        queue_byte(8'hFF);
        queue_byte(8'h0D);
        queue_byte(8'h00);
        queue_byte(CH_LT);
        queue_eoi();
        // open literal flushed at end of input
        queue_text("'ab");
        queue_eoi();

        // Random part; the sender drains the block before its first byte
        // and again halfway through
        hold_next = 1'b1;
        while (src_items.size() < 1300) begin
            if (!mid_hold_done && src_items.size() >= 650) begin
                hold_next     = 1'b1;
                mid_hold_done = 1'b1;
            end
            queue_random_token();
            if ($urandom_range(0, 1) == 1) queue_byte(random_blank());
            if ($urandom_range(0, 39) == 0) queue_eoi();
        end
        queue_eoi();

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (src_items.size() != 0 || s_axis_tvalid) @(posedge aclk);
        while (tokens_due.size() != 0) @(posedge aclk);
        // keep running so that a stray extra token would show
        repeat (8) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run
    initial begin
        #5000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
